>>> rtl/bnsd_pkg.sv
// package for the block nibble sample decoder
// holds block geometry constants and the sample scaling and float helpers
package bnsd_pkg;

  localparam int unsigned BlockBytes  = 9;
  localparam int unsigned DataBytes   = 8;
  localparam int unsigned BufAddrW    = 3;
  localparam int unsigned SampleW     = 11;
  localparam int unsigned FloatW      = 32;
  localparam int unsigned PosW        = 4;
  localparam int unsigned NibIdxW     = 4;

  // sign-magnitude nibble times 2^(sign-magnitude range), truncated toward zero
  function automatic logic signed [SampleW-1:0] scale_nibble(input logic [3:0] nib,
                                                            input logic [3:0] rng);
    logic [SampleW-1:0] mag;
    logic [SampleW-1:0] val;
    mag = {{(SampleW-3){1'b0}}, nib[2:0]};
    if (rng[3]) val = mag >> rng[2:0];
    else        val = mag << rng[2:0];
    if (nib[3]) scale_nibble = -$signed(val);
    else        scale_nibble = $signed(val);
  endfunction

  // exact single-precision word of v / 32768
  function automatic logic [FloatW-1:0] to_float_word(input logic signed [SampleW-1:0] v);
    logic [SampleW-1:0] m;
    logic [3:0]         p;
    logic [22:0]        mant;
    logic [7:0]         expo;
    m = v[SampleW-1] ? SampleW'(-v) : SampleW'(v);
    p = '0;
    for (int i = 0; i < SampleW; i++) begin
      if (m[i]) p = 4'(i);
    end
    expo = 8'(p) + 8'd112;
    mant = 23'({m, 12'b0} << (4'd11 - p));
    if (m == '0) to_float_word = '0;
    else         to_float_word = {v[SampleW-1], expo, mant};
  endfunction

endpackage

>>> rtl/bnsd_if.sv
// valid/ready channel interfaces for the block nibble sample decoder
// depends on bnsd_pkg for field widths
interface bnsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bnsd_out_if;
  logic                              valid;
  logic                              ready;
  logic [bnsd_pkg::FloatW-1:0]       float_bits;
  logic signed [bnsd_pkg::SampleW-1:0] sample_value;
  logic                              last_in_block;
  modport source (output valid, output float_bits, output sample_value,
                  output last_in_block, input ready);
  modport sink   (input valid, input float_bits, input sample_value,
                  input last_in_block, output ready);
endinterface

>>> rtl/bnsd_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module bnsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bnsd_emit.sv
// output stage: turns a buffered data byte nibble into a sample and float word
// depends on bnsd_pkg and bnsd_out_if
module bnsd_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_valid,
  input  logic [7:0]                 rd_byte,
  input  logic                       rd_lower,
  input  logic                       rd_last,
  input  logic [3:0]                 range,
  output logic                       busy,
  bnsd_out_if.source                 out_ch
);
  import bnsd_pkg::*;

  logic                      valid_r;
  logic signed [SampleW-1:0] sample_r;
  logic [FloatW-1:0]         float_r;
  logic                      last_r;
  logic signed [SampleW-1:0] s;

  assign s    = scale_nibble(rd_lower ? rd_byte[3:0] : rd_byte[7:4], range);
  assign busy = valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rd_valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
    if (rd_valid) begin
      sample_r <= s;
      float_r  <= to_float_word(s);
      last_r   <= rd_last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.sample_value  = sample_r;
  assign out_ch.float_bits    = float_r;
  assign out_ch.last_in_block = last_r;
endmodule

>>> rtl/block_nibble_sample_decoder.sv
// top level of the block nibble sample decoder
// depends on bnsd_pkg, bnsd_if, bnsd_ram and bnsd_emit
//
// in channel carries one byte per item; blocks are nine bytes: a header whose
// upper nibble is a sign-magnitude range, then eight data bytes kept in a
// small ram. out channel carries one sample per item: the scaled integer, the
// single-precision word of it over 32768, and a flag on the last of sixteen.
// header and the first seven data bytes are accepted while filling. the ninth
// byte starts a sweep of sixteen ram reads; a read is issued only once the
// one before it has reached the output register, so only one read is in
// flight ahead of it. each sample passes through the ram read register and
// then the emitter's sample register. no input is taken during the sweep.
// a stalled receiver holds the sample register and freezes the sweep until
// it is taken. reset returns to waiting for a header; the data ram needs no
// clearing since each entry is written before read.
module block_nibble_sample_decoder (
  input logic        clk,
  input logic        rst_n,
  bnsd_in_if.sink    in_ch,
  bnsd_out_if.source out_ch
);
  import bnsd_pkg::*;

  typedef enum logic [0:0] {ST_FILL, ST_EMIT} state_t;

  state_t              state_r;
  logic [PosW-1:0]     pos_r;
  logic [3:0]          range_r;
  logic [NibIdxW-1:0]  idx_r;
  logic                rd_valid_r;
  logic                rd_lower_r;
  logic                rd_last_r;
  logic                busy;
  logic                acc;
  logic                issue;
  logic                we;
  logic [7:0]          rdata;

  assign in_ch.ready = (state_r == ST_FILL);
  assign acc   = in_ch.valid && in_ch.ready;
  assign we    = acc && (pos_r != '0);
  // one read in flight at most ahead of the output register
  assign issue = (state_r == ST_EMIT) && !busy && !rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      pos_r      <= '0;
      range_r    <= '0;
      idx_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      case (state_r)
        ST_FILL: begin
          if (acc) begin
            if (pos_r == '0) begin
              range_r <= in_ch.in_byte[7:4];
              pos_r   <= PosW'(1);
            end else if (pos_r == PosW'(BlockBytes - 1)) begin
              pos_r   <= '0;
              idx_r   <= '0;
              state_r <= ST_EMIT;
            end else begin
              pos_r <= pos_r + PosW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            idx_r <= idx_r + NibIdxW'(1);
            if (idx_r == '1) state_r <= ST_FILL;
          end
        end
        default: state_r <= ST_FILL;
      endcase
    end
    rd_lower_r <= idx_r[0];
    rd_last_r  <= (idx_r == '1);
  end

  bnsd_ram #(.Width(8), .Depth(DataBytes)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (BufAddrW'(pos_r - PosW'(1))),
    .wdata (in_ch.in_byte),
    .raddr (idx_r[NibIdxW-1:1]),
    .rdata (rdata)
  );

  bnsd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (rd_valid_r),
    .rd_byte  (rdata),
    .rd_lower (rd_lower_r),
    .rd_last  (rd_last_r),
    .range    (range_r),
    .busy     (busy),
    .out_ch   (out_ch)
  );
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for block_nibble_sample_decoder
// depends on bnsd_pkg and the bnsd_in_if / bnsd_out_if channel interfaces
module tb;
  import bnsd_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomBlocks = 16;
  localparam int unsigned DrainCycles  = 40;

  typedef struct {
    logic [FloatW-1:0]         fw;
    logic signed [SampleW-1:0] sv;
    logic                      last;
  } sample_t;

  typedef struct {
    logic [7:0]                b;
    bit                        typed;
    logic signed [SampleW-1:0] t_sv;
    logic [FloatW-1:0]         t_fw;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_req;
  int   hold_left;

  // decoder state as the predictor sees it
  logic [3:0] pos;
  logic [3:0] hdr_range;
  logic [7:0] data_bytes [DataBytes];
  sample_t    sample_q [$];

  bnsd_in_if  in_ch ();
  bnsd_out_if out_ch ();

  block_nibble_sample_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_row_t directed [18] = '{
    '{8'h70, 1'b0, '0, '0}, '{8'h7F, 1'b0, '0, '0}, '{8'h80, 1'b0, '0, '0},
    '{8'h08, 1'b0, '0, '0}, '{8'h12, 1'b0, '0, '0}, '{8'h34, 1'b0, '0, '0},
    '{8'h56, 1'b0, '0, '0}, '{8'h9A, 1'b0, '0, '0},
    '{8'hBC, 1'b1, 11'sd896, 32'h3CE0_0000},
    // range -7 with a non-zero lower header nibble: everything shifts out to +0
    '{8'hF5, 1'b0, '0, '0}, '{8'h7F, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
    '{8'h00, 1'b0, '0, '0}, '{8'h88, 1'b0, '0, '0}, '{8'h11, 1'b0, '0, '0},
    '{8'h77, 1'b0, '0, '0}, '{8'hEE, 1'b0, '0, '0},
    '{8'h70, 1'b1, 11'sd0, 32'h0000_0000}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [SampleW-1:0] scaled(input logic [3:0] nib,
                                                       input logic [3:0] rng);
    int unsigned mag;
    mag = rng[3] ? (nib[2:0] >> rng[2:0]) : (nib[2:0] << rng[2:0]);
    return (nib[3] && mag != 0) ? -SampleW'(mag) : SampleW'(mag);
  endfunction

  // exact single-precision word of s / 32768
  function automatic logic [FloatW-1:0] float_word(input logic signed [SampleW-1:0] s);
    int unsigned mag;
    int unsigned msb;
    logic [22:0] frac;
    mag = (s < 0) ? -s : s;
    if (mag == 0) return '0;
    msb = 0;
    while ((mag >> (msb + 1)) != 0) msb++;
    frac = 23'(mag << (23 - msb));
    return {s < 0, 8'(msb + 112), frac};
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    logic [3:0]                nib;
    logic signed [SampleW-1:0] s;
    if (pos == 0) begin
      hdr_range = b[7:4];
      pos = 1;
    end else begin
      data_bytes[pos - 1] = b;
      if (pos < BlockBytes - 1) begin
        pos++;
      end else begin
        pos = 0;
        for (int k = 0; k < 16; k++) begin
          nib = k[0] ? data_bytes[k / 2][3:0] : data_bytes[k / 2][7:4];
          s = scaled(nib, hdr_range);
          sample_q.push_back('{float_word(s), s, k == 15});
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b);
  endtask

  function automatic logic [3:0] rand_nibble();
    // lean on the extremes and the negative zero
    case ($urandom_range(3))
      0: return 4'($urandom_range(1) ? 7 : 15);
      1: return 4'($urandom_range(1) ? 8 : 0);
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sample_q.size() == 0) begin
          report("unexpected sample", out_ch.sample_value, 0);
        end else begin
          want = sample_q.pop_front();
          if (out_ch.float_bits !== want.fw) report("float_bits", out_ch.float_bits, want.fw);
          if (out_ch.sample_value !== want.sv)
            report("sample_value", out_ch.sample_value, want.sv);
          if (out_ch.last_in_block !== want.last)
            report("last_in_block", out_ch.last_in_block, want.last);
        end
      end
      if (hold_req != 0) begin
        hold_left    <= hold_req;
        hold_req     = 0;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    logic [3:0] hi;
    logic [3:0] lo;
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    pos           = 0;
    hdr_range     = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_byte(directed[i].b);
      if (directed[i].typed) begin
        if (sample_q[sample_q.size() - 16].sv !== directed[i].t_sv)
          report("predicted sample", sample_q[sample_q.size() - 16].sv, directed[i].t_sv);
        if (sample_q[sample_q.size() - 16].fw !== directed[i].t_fw)
          report("predicted float", sample_q[sample_q.size() - 16].fw, directed[i].t_fw);
      end
    end

    for (int blk = 0; blk < RandomBlocks; blk++) begin
      case (blk / 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      // long receiver hold-off while the sender keeps offering bytes
      if (blk == 2) hold_req = 300;
      send_byte(8'($urandom_range(255)));
      for (int j = 0; j < 8; j++) begin
        hi = rand_nibble();
        lo = rand_nibble();
        send_byte({hi, lo});
      end
    end

    // partial trailing block with a negative-zero range: nothing comes out
    send_idle_pct = 0;
    stall_pct     = 0;
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h07);
    in_ch.valid <= 1'b0;

    while (sample_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bnsd_pkg.sv
rtl/bnsd_if.sv
rtl/bnsd_ram.sv
rtl/bnsd_emit.sv
rtl/block_nibble_sample_decoder.sv
tb/sv/tb.sv
